// ----- hw/rtl/priority_message_queue_defines.svh -----
// ----------------------------------------------------------------------------
// Priority message queue assertion macros
// Shared property shapes for the checker of the priority message queue.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_MESSAGE_QUEUE_DEFINES_SVH
`define PRIORITY_MESSAGE_QUEUE_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define PMQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("priority message queue check failed");

// Next-cycle implication, checked while out of reset.
`define PMQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("priority message queue check failed");

`endif

// ----- hw/rtl/pmq_pkg.sv -----
// ----------------------------------------------------------------------------
// Priority message queue package
// Sizes, codes and shared types of the priority message queue.
// ----------------------------------------------------------------------------
`default_nettype none

package pmq_pkg;

    localparam int SLOTS     = 64;
    localparam int MAX_BYTES = 64;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int LINK_W    = SLOT_W + 1;
    localparam int BYTE_W    = $clog2(MAX_BYTES);
    localparam int PAY_AW    = SLOT_W + BYTE_W;
    localparam int PAY_DEPTH = SLOTS * MAX_BYTES;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(SLOTS);
    localparam logic [6:0]        SLOTS_7   = 7'(SLOTS);
    localparam logic [6:0]        MAXB_7    = 7'(MAX_BYTES);

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_LONG  = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_SMALL_BUF = 3'd4;

    localparam logic CMD_SEND = 1'b0;
    localparam logic CMD_RECV = 1'b1;

    localparam logic CFG_MAX_MSGS  = 1'b0;
    localparam logic CFG_MAX_BYTES = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_COLLECT,
        PH_DROP_FULL,
        PH_DROP_LONG
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP,
        S_INS_START,
        S_INS_CHK,
        S_INS_W1,
        S_INS_W2,
        S_RX_RD,
        S_RX_ZLEN,
        S_RX_PRD,
        S_RX_OUT
    } t_state;

    typedef struct packed {
        logic              link_we;
        logic              meta_we;
        logic [SLOT_W-1:0] addr;
        logic [LINK_W-1:0] link;
        logic [15:0]       prio;
        logic [6:0]        len;
    } t_slot_wr;

endpackage

`default_nettype wire

// ----- hw/rtl/pmq_slot_mem.sv -----
// ----------------------------------------------------------------------------
// Slot memory
// Link, priority and length of every slot; links read as a chain until written.
// ----------------------------------------------------------------------------
`default_nettype none

module pmq_slot_mem
    import pmq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rd_en,
    input  wire logic [SLOT_W-1:0] i_rd_addr,
    input  wire t_slot_wr          i_wr,
    output logic [LINK_W-1:0]      o_link,
    output logic [15:0]            o_prio,
    output logic [6:0]             o_len
);

    logic [LINK_W-1:0] r_link_mem [SLOTS];
    logic [15:0]       r_prio_mem [SLOTS];
    logic [6:0]        r_len_mem  [SLOTS];
    logic [SLOTS-1:0]  r_link_vld;
    logic [LINK_W-1:0] r_link_q;
    logic [SLOT_W-1:0] r_rd_idx;
    logic              r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_vld <= '0;
        end else if (i_wr.link_we) begin
            r_link_vld[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.link_we) begin
            r_link_mem[i_wr.addr] <= i_wr.link;
        end
        if (i_wr.meta_we) begin
            r_prio_mem[i_wr.addr] <= i_wr.prio;
            r_len_mem[i_wr.addr]  <= i_wr.len;
        end
        if (i_rd_en) begin
            r_link_q <= r_link_mem[i_rd_addr];
            o_prio   <= r_prio_mem[i_rd_addr];
            o_len    <= r_len_mem[i_rd_addr];
            r_rd_idx <= i_rd_addr;
            r_rd_vld <= r_link_vld[i_rd_addr];
        end
    end

    assign o_link = r_rd_vld ? r_link_q : LINK_W'({1'b0, r_rd_idx} + 1'b1);

endmodule

`default_nettype wire

// ----- hw/rtl/pmq_payload_mem.sv -----
// ----------------------------------------------------------------------------
// Payload memory
// Byte store of all slots, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pmq_payload_mem
    import pmq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [PAY_AW-1:0] i_waddr,
    input  wire logic [7:0]        i_wdata,
    input  wire logic              i_re,
    input  wire logic [PAY_AW-1:0] i_raddr,
    output logic [7:0]             o_rdata
);

    logic [7:0] r_mem [PAY_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/priority_message_queue.sv -----
// Send beat: taken in idle; the first beat of a message adds the free-list pop (S_POP).
// A committed send walks the queue one node per cycle (S_INS_CHK) before its result.
// A receive reads the slot, then for each byte reads the payload memory (S_RX_PRD) and sends it (S_RX_OUT).
// Error results leave in the cycle after the request; one request is worked at a time.
// Reset (synchronous, active low): queue empty, all slots free, limits at 64.
// ----------------------------------------------------------------------------
// Priority message queue
// Slot store linked into a priority-ordered queue and a free list.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_message_queue
    import pmq_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [6:0]  i_cfg_data,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // data_byte[7:0], byte_present[8], priority_req[24:9], buffer_len[32:25]
    input  wire logic [39:0] i_s_axis_tdata,
    input  wire logic        i_s_axis_tlast,
    // cmd[0]
    input  wire logic        i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // status[2:0], data_out[10:3], out_priority[26:11], message_length[33:27],
    // message_count[40:34]
    output logic [47:0]      o_m_axis_tdata,
    output logic             o_m_axis_tlast,
    // byte_valid[0]
    output logic             o_m_axis_tuser
);

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic [SLOT_W-1:0] r_slot, n_slot, r_rx_slot, n_rx_slot;
    logic [6:0]  r_bytes, n_bytes, r_count, n_count, r_n, n_n;
    logic [6:0]  r_rx_len, n_rx_len, r_rx_i, n_rx_i;
    logic [6:0]  r_max_msgs, r_max_bytes;
    logic [15:0] r_prio, n_prio, r_rx_prio, n_rx_prio;
    logic        r_commit, n_commit;
    logic [LINK_W-1:0] r_qhead, n_qhead, r_fhead, n_fhead;
    logic [LINK_W-1:0] r_cur, n_cur, r_prev, n_prev;

    logic        r_ovalid, n_ovalid, r_olast, n_olast, r_obv, n_obv;
    logic [2:0]  r_ost, n_ost;
    logic [7:0]  r_odata, n_odata;
    logic [15:0] r_oprio, n_oprio;
    logic [6:0]  r_olen, n_olen, r_ocnt, n_ocnt;

    logic              sm_rd_en;
    logic [SLOT_W-1:0] sm_rd_addr;
    t_slot_wr          sm_wr;
    logic [LINK_W-1:0] sm_link;
    logic [15:0]       sm_prio;
    logic [6:0]        sm_len;

    logic              pl_we, pl_re;
    logic [PAY_AW-1:0] pl_waddr, pl_raddr;
    logic [7:0]        pl_rdata;

    logic        in_fire, out_free;
    logic [7:0]  in_byte, in_blen;
    logic        in_present;
    logic [15:0] in_prio;
    logic [6:0]  eff_m, eff_b, bytes0, bytes1, len_clip;
    logic        first, full, pop, release_s, toolong, commit, pl_ok;
    t_phase      ph0, ph1;
    logic [SLOT_W-1:0] slot0;
    logic [LINK_W-1:0] chk_next, link_norm;
    logic        chk_stop;

    pmq_slot_mem u_slot_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (sm_rd_en),
        .i_rd_addr (sm_rd_addr),
        .i_wr      (sm_wr),
        .o_link    (sm_link),
        .o_prio    (sm_prio),
        .o_len     (sm_len)
    );

    pmq_payload_mem u_payload_mem (
        .i_clk   (i_clk),
        .i_we    (pl_we),
        .i_waddr (pl_waddr),
        .i_wdata (in_byte),
        .i_re    (pl_re),
        .i_raddr (pl_raddr),
        .o_rdata (pl_rdata)
    );

    assign in_byte    = i_s_axis_tdata[7:0];
    assign in_present = i_s_axis_tdata[8];
    assign in_prio    = i_s_axis_tdata[24:9];
    assign in_blen    = i_s_axis_tdata[32:25];

    assign out_free        = !r_ovalid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && out_free;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {7'd0, r_ocnt, r_olen, r_oprio, r_odata, r_ost};
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tuser  = r_obv;

    assign eff_m = (r_max_msgs < SLOTS_7) ? r_max_msgs : SLOTS_7;
    assign eff_b = (r_max_bytes < MAXB_7) ? r_max_bytes : MAXB_7;

    // Send beat evaluation.
    always_comb begin
        first     = (r_phase == PH_IDLE);
        full      = (r_count >= eff_m) || (r_fhead >= NULL_LINK);
        bytes0    = first ? 7'd0 : r_bytes;
        pop       = first && !full;
        ph0       = first ? (full ? PH_DROP_FULL : PH_COLLECT) : r_phase;
        slot0     = pop ? r_fhead[SLOT_W-1:0] : r_slot;
        ph1       = ph0;
        bytes1    = bytes0;
        release_s = 1'b0;
        pl_ok     = 1'b0;
        if (in_present) begin
            if (bytes0 < eff_b) begin
                pl_ok  = (ph0 == PH_COLLECT);
                bytes1 = bytes0 + 7'd1;
            end else begin
                bytes1    = eff_b + 7'd1;
                release_s = (ph0 == PH_COLLECT);
                ph1       = PH_DROP_LONG;
            end
        end
        toolong = (ph1 == PH_DROP_LONG) || (bytes1 > eff_b);
        if (i_s_axis_tlast && toolong && ph1 == PH_COLLECT) begin
            release_s = 1'b1;
        end
        commit = i_s_axis_tlast && !toolong && (ph1 == PH_COLLECT);
    end

    assign link_norm = (sm_link >= NULL_LINK) ? NULL_LINK : sm_link;
    assign chk_next  = link_norm;
    assign chk_stop  = (r_prio > sm_prio) || (chk_next == NULL_LINK)
                       || (r_n + 7'd1 >= SLOTS_7);
    assign len_clip  = (sm_len > MAXB_7) ? MAXB_7 : sm_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_msgs  <= SLOTS_7;
            r_max_bytes <= MAXB_7;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAX_MSGS:  r_max_msgs  <= i_cfg_data;
                CFG_MAX_BYTES: r_max_bytes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_s_axis_tuser == CMD_RECV) begin
                        if (in_blen >= {1'b0, eff_b} && r_count != 7'd0
                            && r_qhead < NULL_LINK) begin
                            n_state = S_RX_RD;
                        end
                    end else if (pop && !release_s) begin
                        n_state = S_POP;
                    end else if (commit) begin
                        n_state = S_INS_START;
                    end
                end
            end
            S_POP:       n_state = r_commit ? S_INS_START : S_IDLE;
            S_INS_START: n_state = (r_qhead == NULL_LINK) ? S_INS_W1 : S_INS_CHK;
            S_INS_CHK:   n_state = chk_stop ? S_INS_W1 : S_INS_CHK;
            S_INS_W1:    n_state = S_INS_W2;
            S_INS_W2:    n_state = out_free ? S_IDLE : S_INS_W2;
            S_RX_RD:     n_state = (len_clip == 7'd0) ? S_RX_ZLEN : S_RX_PRD;
            S_RX_ZLEN:   n_state = out_free ? S_IDLE : S_RX_ZLEN;
            S_RX_PRD:    n_state = S_RX_OUT;
            S_RX_OUT: begin
                if (out_free) begin
                    n_state = (r_rx_i + 7'd1 == r_rx_len) ? S_IDLE : S_RX_PRD;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // Datapath, memory requests and results.
    always_comb begin
        n_phase = r_phase;   n_slot = r_slot;     n_bytes = r_bytes;
        n_prio = r_prio;     n_commit = r_commit; n_qhead = r_qhead;
        n_fhead = r_fhead;   n_count = r_count;   n_cur = r_cur;
        n_prev = r_prev;     n_n = r_n;           n_rx_slot = r_rx_slot;
        n_rx_len = r_rx_len; n_rx_prio = r_rx_prio; n_rx_i = r_rx_i;
        n_ovalid = r_ovalid && !i_m_axis_tready;
        n_ost = r_ost;   n_odata = r_odata; n_obv = r_obv; n_oprio = r_oprio;
        n_olen = r_olen; n_ocnt = r_ocnt;   n_olast = r_olast;
        sm_rd_en = 1'b0;
        sm_rd_addr = r_fhead[SLOT_W-1:0];
        sm_wr = '0;
        pl_we = 1'b0;
        pl_waddr = {slot0, bytes0[BYTE_W-1:0]};
        pl_re = 1'b0;
        pl_raddr = {r_rx_slot, r_rx_i[BYTE_W-1:0]};

        unique case (r_state)
            S_IDLE: begin
                if (in_fire && i_s_axis_tuser == CMD_RECV) begin
                    n_ovalid = 1'b1;
                    n_odata  = 8'd0;
                    n_obv    = 1'b0;
                    n_oprio  = 16'd0;
                    n_olen   = 7'd0;
                    n_ocnt   = r_count;
                    n_olast  = 1'b1;
                    if (in_blen < {1'b0, eff_b}) begin
                        n_ost = ST_SMALL_BUF;
                    end else if (r_count == 7'd0 || r_qhead >= NULL_LINK) begin
                        n_ost = ST_EMPTY;
                    end else begin
                        n_ovalid   = r_ovalid && !i_m_axis_tready;
                        n_ost      = r_ost;
                        n_odata    = r_odata;
                        n_obv      = r_obv;
                        n_oprio    = r_oprio;
                        n_olen     = r_olen;
                        n_ocnt     = r_ocnt;
                        n_olast    = r_olast;
                        sm_rd_en   = 1'b1;
                        sm_rd_addr = r_qhead[SLOT_W-1:0];
                        n_rx_slot  = r_qhead[SLOT_W-1:0];
                    end
                end else if (in_fire) begin
                    pl_we    = in_present && pl_ok;
                    n_slot   = slot0;
                    n_prio   = in_prio;
                    n_commit = commit;
                    if (pop && !release_s) begin
                        sm_rd_en   = 1'b1;
                        sm_rd_addr = r_fhead[SLOT_W-1:0];
                    end else if (release_s && !pop) begin
                        sm_wr.link_we = 1'b1;
                        sm_wr.addr    = slot0;
                        sm_wr.link    = r_fhead;
                        n_fhead       = {1'b0, slot0};
                    end
                    if (commit) begin
                        sm_wr.meta_we = 1'b1;
                        sm_wr.addr    = slot0;
                        sm_wr.prio    = in_prio;
                        sm_wr.len     = bytes1;
                    end
                    if (i_s_axis_tlast) begin
                        n_phase = PH_IDLE;
                        n_bytes = 7'd0;
                        if (!commit) begin
                            n_ovalid = 1'b1;
                            n_ost    = toolong ? ST_TOO_LONG : ST_FULL;
                            n_odata  = 8'd0;
                            n_obv    = 1'b0;
                            n_oprio  = 16'd0;
                            n_olen   = 7'd0;
                            n_ocnt   = r_count;
                            n_olast  = 1'b1;
                        end
                    end else begin
                        n_phase = ph1;
                        n_bytes = bytes1;
                    end
                end
            end
            S_POP: begin
                n_fhead = sm_link;
            end
            S_INS_START: begin
                n_prev = NULL_LINK;
                n_cur  = r_qhead;
                n_n    = 7'd0;
                if (r_qhead != NULL_LINK) begin
                    sm_rd_en   = 1'b1;
                    sm_rd_addr = r_qhead[SLOT_W-1:0];
                end
            end
            S_INS_CHK: begin
                if (r_prio <= sm_prio) begin
                    n_prev = r_cur;
                    n_cur  = chk_next;
                    n_n    = r_n + 7'd1;
                    if (!chk_stop) begin
                        sm_rd_en   = 1'b1;
                        sm_rd_addr = chk_next[SLOT_W-1:0];
                    end
                end
            end
            S_INS_W1: begin
                sm_wr.link_we = 1'b1;
                sm_wr.addr    = r_slot;
                sm_wr.link    = r_cur;
            end
            S_INS_W2: begin
                if (out_free) begin
                    if (r_prev == NULL_LINK) begin
                        n_qhead = {1'b0, r_slot};
                    end else begin
                        sm_wr.link_we = 1'b1;
                        sm_wr.addr    = r_prev[SLOT_W-1:0];
                        sm_wr.link    = {1'b0, r_slot};
                    end
                    n_count  = r_count + 7'd1;
                    n_ovalid = 1'b1;
                    n_ost    = ST_OK;
                    n_odata  = 8'd0;
                    n_obv    = 1'b0;
                    n_oprio  = 16'd0;
                    n_olen   = 7'd0;
                    n_ocnt   = r_count + 7'd1;
                    n_olast  = 1'b1;
                end
            end
            S_RX_RD: begin
                n_qhead       = link_norm;
                n_rx_len      = len_clip;
                n_rx_prio     = sm_prio;
                n_rx_i        = 7'd0;
                sm_wr.link_we = 1'b1;
                sm_wr.addr    = r_rx_slot;
                sm_wr.link    = r_fhead;
                n_fhead       = {1'b0, r_rx_slot};
                n_count       = r_count - 7'd1;
            end
            S_RX_ZLEN: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ost    = ST_OK;
                    n_odata  = 8'd0;
                    n_obv    = 1'b0;
                    n_oprio  = r_rx_prio;
                    n_olen   = 7'd0;
                    n_ocnt   = r_count;
                    n_olast  = 1'b1;
                end
            end
            S_RX_PRD: begin
                pl_re = 1'b1;
            end
            S_RX_OUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ost    = ST_OK;
                    n_odata  = pl_rdata;
                    n_obv    = 1'b1;
                    n_oprio  = r_rx_prio;
                    n_olen   = r_rx_len;
                    n_ocnt   = r_count;
                    n_olast  = (r_rx_i + 7'd1 == r_rx_len);
                    n_rx_i   = r_rx_i + 7'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_IDLE;
            r_slot   <= '0;
            r_bytes  <= 7'd0;
            r_qhead  <= NULL_LINK;
            r_fhead  <= '0;
            r_count  <= 7'd0;
            r_commit <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_slot   <= n_slot;
            r_bytes  <= n_bytes;
            r_qhead  <= n_qhead;
            r_fhead  <= n_fhead;
            r_count  <= n_count;
            r_commit <= n_commit;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio    <= n_prio;
        r_cur     <= n_cur;
        r_prev    <= n_prev;
        r_n       <= n_n;
        r_rx_slot <= n_rx_slot;
        r_rx_len  <= n_rx_len;
        r_rx_prio <= n_rx_prio;
        r_rx_i    <= n_rx_i;
        r_ost     <= n_ost;
        r_odata   <= n_odata;
        r_obv     <= n_obv;
        r_oprio   <= n_oprio;
        r_olen    <= n_olen;
        r_ocnt    <= n_ocnt;
        r_olast   <= n_olast;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/pmq_checker.sv -----
// ----------------------------------------------------------------------------
// Priority message queue checker
// Port-level checks on the result stream of the priority message queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "priority_message_queue_defines.svh"

module pmq_checker
    import pmq_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [47:0] i_m_axis_tdata,
    input wire logic        i_m_axis_tlast,
    input wire logic        i_m_axis_tuser
);

    `PMQ_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_m_axis_tvalid && !i_m_axis_tready, i_m_axis_tvalid && $stable(i_m_axis_tdata))
    `PMQ_ASSERT_NOW(a_error_single, i_clk, i_rst_n, i_m_axis_tvalid && i_m_axis_tdata[2:0] != ST_OK, i_m_axis_tlast && !i_m_axis_tuser)
    `PMQ_ASSERT_NOW(a_byte_ok, i_clk, i_rst_n, i_m_axis_tvalid && i_m_axis_tuser, i_m_axis_tdata[2:0] == ST_OK && i_m_axis_tdata[33:27] != 7'd0)
    `PMQ_ASSERT_NOW(a_count_max, i_clk, i_rst_n, i_m_axis_tvalid, i_m_axis_tdata[40:34] <= SLOTS_7)
    `PMQ_ASSERT_NOW(a_no_data, i_clk, i_rst_n, i_m_axis_tvalid && !i_m_axis_tuser, i_m_axis_tdata[10:3] == 8'd0)

endmodule

bind priority_message_queue pmq_checker u_pmq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tlast  (o_m_axis_tlast),
    .i_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire

// ----- verif/priority_message_queue_checker.sv -----
// ----------------------------------------------------------------------------
// Priority message queue checker
// Watches the configuration, request and result channels of the priority
// message queue. It keeps its own copy of the slot store, the linked queue
// and free list, and the send progress, predicts every result of each
// accepted request, and compares the results field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_message_queue_checker
    import pmq_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [6:0]  i_cfg_data,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [39:0] i_s_tdata,
    input  wire logic        i_s_tlast,
    input  wire logic        i_s_tuser,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [47:0] i_m_tdata,
    input  wire logic        i_m_tlast,
    input  wire logic        i_m_tuser,
    output int               o_errors,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  data;
        logic        byte_valid;
        logic [15:0] prio;
        logic [6:0]  len;
        logic [6:0]  count;
        logic        last;
    } t_result;

    t_result     queued_results[$];
    logic [7:0]  payload_mem[PAY_DEPTH];
    int          link_mem[SLOTS];
    logic [15:0] prio_mem[SLOTS];
    int          len_mem[SLOTS];
    int          q_head, f_head, held, fill_slot, fill_bytes;
    t_phase      fill_phase;
    int          lim_msgs, lim_bytes;

    assign o_pending = queued_results.size();

    function automatic int msg_limit();
        return lim_msgs < SLOTS ? lim_msgs : SLOTS;
    endfunction

    function automatic int byte_limit();
        return lim_bytes < MAX_BYTES ? lim_bytes : MAX_BYTES;
    endfunction

    function automatic void push_result(logic [2:0] st, logic [7:0] d, logic bv,
                                        logic [15:0] p, int len, logic lst);
        t_result r;
        r.status = st; r.data = d; r.byte_valid = bv; r.prio = p;
        r.len = 7'(len); r.count = 7'(held); r.last = lst;
        queued_results.push_back(r);
    endfunction

    function automatic void free_slot(int s);
        link_mem[s] = f_head;
        f_head = s;
    endfunction

    function automatic void link_by_priority(int s, logic [15:0] p);
        int prev, cur;
        prev = SLOTS;
        cur = q_head;
        while (cur < SLOTS && p <= prio_mem[cur]) begin
            prev = cur;
            cur = link_mem[cur];
        end
        link_mem[s] = cur;
        if (prev >= SLOTS) q_head = s;
        else link_mem[prev] = s;
        held++;
    endfunction

    function automatic void predict_send(logic [7:0] d, logic present, logic lst,
                                         logic [15:0] p);
        int lim;
        lim = byte_limit();
        if (fill_phase == PH_IDLE) begin
            fill_bytes = 0;
            if (held >= msg_limit() || f_head >= SLOTS) begin
                fill_phase = PH_DROP_FULL;
            end else begin
                fill_slot = f_head;
                f_head = link_mem[fill_slot];
                fill_phase = PH_COLLECT;
            end
        end
        if (present) begin
            if (fill_bytes < lim) begin
                if (fill_phase == PH_COLLECT) payload_mem[fill_slot * MAX_BYTES + fill_bytes] = d;
                fill_bytes++;
            end else begin
                fill_bytes = lim + 1;
                if (fill_phase == PH_COLLECT) free_slot(fill_slot);
                fill_phase = PH_DROP_LONG;
            end
        end
        if (!lst) return;
        if (fill_phase == PH_DROP_LONG || fill_bytes > lim) begin
            if (fill_phase == PH_COLLECT) free_slot(fill_slot);
            push_result(ST_TOO_LONG, 0, 0, 0, 0, 1);
        end else if (fill_phase == PH_DROP_FULL) begin
            push_result(ST_FULL, 0, 0, 0, 0, 1);
        end else begin
            prio_mem[fill_slot] = p;
            len_mem[fill_slot] = fill_bytes;
            link_by_priority(fill_slot, p);
            push_result(ST_OK, 0, 0, 0, 0, 1);
        end
        fill_phase = PH_IDLE;
        fill_bytes = 0;
    endfunction

    function automatic void predict_receive(int blen);
        int s, len;
        logic [15:0] p;
        if (blen < byte_limit()) begin
            push_result(ST_SMALL_BUF, 0, 0, 0, 0, 1);
            return;
        end
        if (held == 0 || q_head >= SLOTS) begin
            push_result(ST_EMPTY, 0, 0, 0, 0, 1);
            return;
        end
        s = q_head;
        q_head = link_mem[s];
        len = len_mem[s];
        p = prio_mem[s];
        free_slot(s);
        held--;
        if (len == 0) begin
            push_result(ST_OK, 0, 0, p, 0, 1);
            return;
        end
        for (int i = 0; i < len; i++)
            push_result(ST_OK, payload_mem[s * MAX_BYTES + i], 1, p, len, i + 1 == len);
    endfunction

    task automatic compare_result();
        t_result want, got;
        got.status = i_m_tdata[2:0];
        got.data = i_m_tdata[10:3];
        got.prio = i_m_tdata[26:11];
        got.len = i_m_tdata[33:27];
        got.count = i_m_tdata[40:34];
        got.byte_valid = i_m_tuser;
        got.last = i_m_tlast;
        if (queued_results.size() == 0) begin
            $error("unexpected result, tdata %h", i_m_tdata);
            o_errors++;
            return;
        end
        want = queued_results.pop_front();
        if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status); o_errors++;
        end
        if (got.data !== want.data) begin
            $error("data_out: expected %0h, actual %0h", want.data, got.data); o_errors++;
        end
        if (got.byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %0b, actual %0b", want.byte_valid, got.byte_valid);
            o_errors++;
        end
        if (got.prio !== want.prio) begin
            $error("out_priority: expected %0h, actual %0h", want.prio, got.prio); o_errors++;
        end
        if (got.len !== want.len) begin
            $error("message_length: expected %0d, actual %0d", want.len, got.len); o_errors++;
        end
        if (got.count !== want.count) begin
            $error("message_count: expected %0d, actual %0d", want.count, got.count);
            o_errors++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, got.last); o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) link_mem[i] = i + 1;
            q_head = SLOTS; f_head = 0; held = 0; fill_slot = 0; fill_bytes = 0;
            fill_phase = PH_IDLE; lim_msgs = 64; lim_bytes = 64;
            o_errors = 0;
            queued_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) compare_result();
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_MAX_MSGS) lim_msgs = i_cfg_data;
                else lim_bytes = i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == CMD_SEND)
                    predict_send(i_s_tdata[7:0], i_s_tdata[8], i_s_tlast, i_s_tdata[24:9]);
                else
                    predict_receive(i_s_tdata[32:25]);
            end
        end
    end

endmodule

`default_nettype wire

// ----- verif/priority_message_queue_tb.sv -----
// ----------------------------------------------------------------------------
// Priority message queue testbench
// Drives sends and receives with random gaps and output stalls through
// several limit settings, and takes the verdict from the checker.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_message_queue_tb
    import pmq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_MAX_MSGS;
    logic [6:0]  cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [39:0] s_data = '0;
    logic        s_last = 1'b0;
    logic        s_user = CMD_SEND;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [47:0] m_data;
    logic        m_last;
    logic        m_user;
    int          errors, pending;
    int          items = 0;
    int          stall_pct = 20;
    int          stall_hold = 0;
    int          cur_bytes = 64;

    always #10 clk = ~clk;

    priority_message_queue DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tlast(s_last), .i_s_axis_tuser(s_user),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tlast(m_last), .o_m_axis_tuser(m_user)
    );

    priority_message_queue_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_s_tvalid(s_valid), .i_s_tready(s_ready), .i_s_tdata(s_data),
        .i_s_tlast(s_last), .i_s_tuser(s_user),
        .i_m_tvalid(m_valid), .i_m_tready(m_ready), .i_m_tdata(m_data),
        .i_m_tlast(m_last), .i_m_tuser(m_user),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge clk) begin
        if (stall_hold > 0) begin
            m_ready <= 1'b0;
            stall_hold <= stall_hold - 1;
        end else if ($urandom_range(0, 99) < 2) begin
            m_ready <= 1'b0;
            stall_hold <= $urandom_range(10, 40);
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    task automatic put_request(logic cmd, logic [7:0] d, logic present, logic lst,
                               logic [15:0] p, logic [7:0] blen);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user <= cmd;
        s_last <= lst;
        s_data <= {7'b0, blen, p, present, d};
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        items++;
    endtask

    task automatic receive_msg(logic [7:0] blen);
        put_request(CMD_RECV, 8'($urandom), 1'($urandom), 1'($urandom), 16'($urandom), blen);
    endtask

    task automatic send_msg(logic [15:0] p, int nbytes, int mix_pct);
        if (nbytes == 0) begin
            put_request(CMD_SEND, 8'($urandom), 1'b0, 1'b1, p, 8'($urandom));
            return;
        end
        for (int i = 0; i < nbytes; i++) begin
            if ($urandom_range(0, 99) < mix_pct)
                put_request(CMD_SEND, 8'($urandom), 1'b0, 1'b0, 16'($urandom), 8'($urandom));
            if ($urandom_range(0, 99) < mix_pct)
                receive_msg($urandom_range(0, 9) < 8 ? 8'($urandom_range(cur_bytes, 255))
                                                     : 8'($urandom));
            put_request(CMD_SEND, 8'($urandom), 1'b1, i == nbytes - 1,
                        i == nbytes - 1 ? p : 16'($urandom), 8'($urandom));
        end
    endtask

    task automatic settle_and_write(int msgs, int nbytes);
        s_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SLOTS + 16) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_MAX_MSGS;
        cfg_data <= 7'(msgs);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_index <= CFG_MAX_BYTES;
        cfg_data <= 7'(nbytes);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        cur_bytes = nbytes;
    endtask

    function automatic logic [15:0] pick_prio();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return 16'($urandom_range(0, 3));
        if (r < 6) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    task automatic random_phase(int budget, int send_pct);
        int stop_at, len;
        stop_at = items + budget;
        while (items < stop_at) begin
            if ($urandom_range(0, 99) < send_pct) begin
                if ($urandom_range(0, 19) == 0) len = $urandom_range(0, cur_bytes + 2);
                else len = $urandom_range(0, cur_bytes < 6 ? cur_bytes + 1 : 6);
                send_msg(pick_prio(), len, 8);
            end else begin
                receive_msg($urandom_range(0, 9) < 8 ? 8'($urandom_range(cur_bytes, 255))
                                                     : 8'($urandom));
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_msg(16'h0000, 0, 0);
        receive_msg(8'hFF);
        receive_msg(8'hFF);
        receive_msg(8'h00);
        send_msg(16'h0005, 3, 0);
        send_msg(16'h0005, 1, 0);
        send_msg(16'hFFFF, 2, 0);
        send_msg(16'h0009, 1, 0);
        receive_msg(8'd64);
        receive_msg(8'd63);
        repeat (3) receive_msg(8'hFF);

        settle_and_write(1, 1);
        send_msg(16'h0001, 1, 0);
        send_msg(16'h0002, 1, 0);
        send_msg(16'h0003, 2, 0);
        receive_msg(8'd0);
        receive_msg(8'd1);
        receive_msg(8'd1);

        settle_and_write(64, 64);
        stall_pct = 0;
        send_msg(16'h1234, 64, 0);
        receive_msg(8'd200);
        random_phase(15, 60);

        settle_and_write(8, 1);
        stall_pct = 50;
        repeat (9) send_msg(pick_prio(), $urandom_range(0, 1), 0);
        repeat (10) receive_msg(8'($urandom_range(1, 255)));

        settle_and_write(3, 8);
        stall_pct = 10;
        random_phase(15, 65);

        settle_and_write($urandom_range(1, 64), $urandom_range(1, 64));
        stall_pct = 30;
        random_phase(12, 55);

        settle_and_write(64, 64);
        random_phase(10, 50);
        repeat (8) receive_msg(8'hFF);

        s_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SLOTS + 16) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("priority_message_queue_tb: done, clean");
        end else begin
            $display("priority_message_queue_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("priority_message_queue_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
